// ===== src/sstf_pkg.sv =====
package sstf_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int MAX_REQUESTERS = 16;
    localparam int TRACK_BITS     = 10;
    localparam int RESULT_CAP     = 16;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int REQ_W  = 4;
    localparam int CFG_W  = 5;
    localparam int CAP_W  = $clog2(RESULT_CAP);
    localparam int CFGI_W = 1;

    typedef enum logic [CFGI_W-1:0] {
        CFG_MAX_QUEUE      = 1'b0,
        CFG_NUM_REQUESTERS = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        REQ_SUBMIT = 1'b0,
        REQ_FINISH = 1'b1
    } t_req_type;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REJECT,
        ST_CHECK,
        ST_SCAN,
        ST_REMOVE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;      // take the input word this cycle
        logic scan_start;  // restart the nearest-track scan at entry zero
        logic scan_step;   // compare one entry
        logic remove;      // retire the chosen entry and move the head
        logic load_rej;    // load a rejection into the output register
        logic load_svc;    // load a service into the output register
        logic last_res;    // mark the loaded word as the last of its input
    } t_dp_cmd;

    typedef struct packed {
        logic bad;         // presented input word would be refused
        logic more_work;   // queue wants another service
        logic scan_done;   // scan is on the final occupied entry
        logic out_free;    // output register can take a word this cycle
    } t_dp_status;

endpackage

// ===== src/sstf_ctrl.sv =====
module sstf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  sstf_pkg::t_dp_status i_stat,
    output sstf_pkg::t_dp_cmd   o_cmd,
    output logic                o_in_stall
);
    import sstf_pkg::*;

    t_state           r_state, n_state;
    logic [CAP_W-1:0] r_svc_cnt, n_svc_cnt;
    logic             cap_hit;
    logic             last_res;

    assign cap_hit  = (r_svc_cnt == CAP_W'(RESULT_CAP - 1));
    assign last_res = cap_hit || !i_stat.more_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_svc_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_svc_cnt <= n_svc_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_svc_cnt = r_svc_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.bad ? ST_REJECT : ST_CHECK;
                end
            end
            ST_REJECT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CHECK: begin
                n_svc_cnt = '0;
                n_state   = i_stat.more_work ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_REMOVE;
                end
            end
            ST_REMOVE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    if (last_res) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_svc_cnt = r_svc_cnt + CAP_W'(1);
                        n_state   = ST_SCAN;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_REJECT: begin
                o_cmd.load_rej = i_stat.out_free;
                o_cmd.last_res = 1'b1;
            end
            ST_CHECK: begin
                o_cmd.scan_start = i_stat.more_work;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_REMOVE: begin
                o_cmd.remove = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.load_svc   = i_stat.out_free;
                o_cmd.last_res   = last_res;
                o_cmd.scan_start = i_stat.out_free && !last_res;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== src/sstf_datapath.sv =====
module sstf_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sstf_pkg::t_dp_cmd                  i_cmd,
    output sstf_pkg::t_dp_status               o_stat,
    input  logic                               i_cfg_we,
    input  logic [sstf_pkg::CFGI_W-1:0]        i_cfg_idx,
    input  logic [sstf_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_req_type,
    input  logic [sstf_pkg::REQ_W-1:0]         i_requester,
    input  logic [sstf_pkg::TRACK_BITS-1:0]    i_track,
    input  logic                               i_final_request,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [sstf_pkg::REQ_W-1:0]         o_served_requester,
    output logic [sstf_pkg::TRACK_BITS-1:0]    o_served_track,
    output logic                               o_rejected,
    output logic                               o_all_done,
    output logic                               o_last_result
);
    import sstf_pkg::*;

    logic [CFG_W-1:0]          r_max_queue;
    logic [CFG_W-1:0]          r_num_req;
    logic [CFG_W-1:0]          mq_eff;
    logic [CFG_W-1:0]          nr_eff;

    logic [TRACK_BITS-1:0]     r_entry_trk [QUEUE_DEPTH];
    logic [REQ_W-1:0]          r_entry_own [QUEUE_DEPTH];
    logic [CNT_W-1:0]          r_count;
    logic [TRACK_BITS-1:0]     r_head;
    logic [MAX_REQUESTERS-1:0] r_outstanding;
    logic [MAX_REQUESTERS-1:0] r_finished;

    logic [REQ_W-1:0]          r_in_who;
    logic [IDX_W-1:0]          r_scan_idx;
    logic [IDX_W-1:0]          r_best_pos;
    logic [TRACK_BITS-1:0]     r_best_trk;
    logic [TRACK_BITS-1:0]     r_best_dist;
    logic [REQ_W-1:0]          r_best_own;

    logic [MAX_REQUESTERS-1:0] active;
    logic                      any_free;
    logic                      all_done;
    logic                      bad;
    logic [TRACK_BITS-1:0]     cur_trk;
    logic [TRACK_BITS-1:0]     cur_dist;
    logic                      take;
    logic                      out_free;

    // Saturate the raw register values into their legal ranges.
    always_comb begin
        mq_eff = r_max_queue;
        if (r_max_queue == '0) mq_eff = CFG_W'(1);
        else if (r_max_queue > CFG_W'(QUEUE_DEPTH)) mq_eff = CFG_W'(QUEUE_DEPTH);
        nr_eff = r_num_req;
        if (r_num_req == '0) nr_eff = CFG_W'(1);
        else if (r_num_req > CFG_W'(MAX_REQUESTERS)) nr_eff = CFG_W'(MAX_REQUESTERS);
    end

    always_comb begin
        for (int i = 0; i < MAX_REQUESTERS; i++) begin
            active[i] = (CFG_W'(i) < nr_eff);
        end
    end

    assign any_free = |(active & ~r_finished & ~r_outstanding);
    assign all_done = (r_count == '0) && ((active & ~r_finished) == '0);

    always_comb begin
        bad = ({1'b0, i_requester} >= nr_eff) || r_finished[i_requester];
        if (i_req_type == REQ_SUBMIT
                && (r_outstanding[i_requester] || r_count >= mq_eff)) begin
            bad = 1'b1;
        end
    end

    assign cur_trk  = r_entry_trk[r_scan_idx];
    assign cur_dist = (cur_trk > r_head) ? cur_trk - r_head : r_head - cur_trk;
    // Strict compare keeps the oldest entry on equal distance.
    assign take     = (r_scan_idx == '0) || (cur_dist < r_best_dist);
    assign out_free = !o_out_valid || !i_out_stall;

    assign o_stat.bad       = bad;
    assign o_stat.more_work = (r_count != '0) && ((r_count >= mq_eff) || !any_free);
    assign o_stat.scan_done = ({1'b0, r_scan_idx} == r_count - CNT_W'(1));
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_queue <= CFG_W'(1);
            r_num_req   <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_QUEUE:      r_max_queue <= i_cfg_data;
                CFG_NUM_REQUESTERS: r_num_req   <= i_cfg_data;
                default:            r_max_queue <= r_max_queue;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_head        <= '0;
            r_outstanding <= '0;
            r_finished    <= '0;
        end else if (i_cmd.accept && !bad) begin
            if (i_req_type == REQ_SUBMIT) begin
                r_count                    <= r_count + CNT_W'(1);
                r_outstanding[i_requester] <= 1'b1;
                if (i_final_request) r_finished[i_requester] <= 1'b1;
            end else begin
                r_finished[i_requester] <= 1'b1;
            end
        end else if (i_cmd.remove) begin
            r_count                   <= r_count - CNT_W'(1);
            r_head                    <= r_best_trk;
            r_outstanding[r_best_own] <= 1'b0;
        end
    end

    // Queue entries: append at the tail, close the gap on removal.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !bad && i_req_type == REQ_SUBMIT) begin
            r_entry_trk[r_count[IDX_W-1:0]] <= i_track;
            r_entry_own[r_count[IDX_W-1:0]] <= i_requester;
        end else if (i_cmd.remove) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (IDX_W'(i) >= r_best_pos) begin
                    r_entry_trk[i] <= r_entry_trk[i+1];
                    r_entry_own[i] <= r_entry_own[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_in_who <= i_requester;
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
            if (take) begin
                r_best_pos  <= r_scan_idx;
                r_best_trk  <= cur_trk;
                r_best_dist <= cur_dist;
                r_best_own  <= r_entry_own[r_scan_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_rej || i_cmd.load_svc) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rej || i_cmd.load_svc) begin
            o_served_requester <= i_cmd.load_rej ? r_in_who : r_best_own;
            o_served_track     <= r_head;
            o_rejected         <= i_cmd.load_rej;
            o_all_done         <= all_done;
            o_last_result      <= i_cmd.last_res;
        end
    end

endmodule

// ===== src/sstf_disk_request_scheduler.sv =====
// Channel   Direction  Handshake               Word
// input     in         i_in_valid / o_in_stall  req_type, requester, track, final_request
// output    out        o_out_valid / i_out_stall served_requester, served_track, rejected,
//                                               all_done, last_result
// config    in         i_cfg_we (no wait)       i_cfg_idx, i_cfg_data
//
// One input word is worked at a time; o_in_stall is low only between words.
// A refused word is taken, then its result is loaded into the output register.
// An accepted word passes a check step, then each service runs the nearest-track
// scan, which reads one queue entry a cycle, then a remove and an emit step.
// Reset (synchronous, active low) empties the queue, homes the head to track 0,
// clears all requester flags and sets both registers to 1; no clearing pass.
// A stall on the output holds the emit step; the last word of an input may wait
// in the output register while the next input word is taken.
module sstf_disk_request_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sstf_pkg::CFGI_W-1:0]     i_cfg_idx,
    input  logic [sstf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [sstf_pkg::REQ_W-1:0]      i_requester,
    input  logic [sstf_pkg::TRACK_BITS-1:0] i_track,
    input  logic                            i_final_request,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sstf_pkg::REQ_W-1:0]      o_served_requester,
    output logic [sstf_pkg::TRACK_BITS-1:0] o_served_track,
    output logic                            o_rejected,
    output logic                            o_all_done,
    output logic                            o_last_result
);
    import sstf_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status stat;

    // Sequence accept, reject, check, scan, remove and emit.
    sstf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Hold the queue, head, requester flags, registers and output word.
    sstf_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_req_type         (i_req_type),
        .i_requester        (i_requester),
        .i_track            (i_track),
        .i_final_request    (i_final_request),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_served_requester (o_served_requester),
        .o_served_track     (o_served_track),
        .o_rejected         (o_rejected),
        .o_all_done         (o_all_done),
        .o_last_result      (o_last_result)
    );

endmodule

// ===== src/sstf_checker.sv =====
module sstf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_stall,
    input logic                            o_out_valid,
    input logic [sstf_pkg::REQ_W-1:0]      o_served_requester,
    input logic [sstf_pkg::TRACK_BITS-1:0] o_served_track,
    input logic                            o_rejected,
    input logic                            o_all_done,
    input logic                            o_last_result
);
    import sstf_pkg::*;

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word survived reset");

    // A stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_served_requester)
            && $stable(o_served_track) && $stable(o_rejected)
            && $stable(o_all_done) && $stable(o_last_result))
        else $error("stalled output word changed");

    // A refusal is always the only word of its input.
    a_rej_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_last_result)
        else $error("refusal not marked last");

    // Once everything is done no further service can follow.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_all_done |-> o_last_result)
        else $error("word after completion");

endmodule

bind sstf_disk_request_scheduler sstf_checker u_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_stall        (i_out_stall),
    .o_out_valid        (o_out_valid),
    .o_served_requester (o_served_requester),
    .o_served_track     (o_served_track),
    .o_rejected         (o_rejected),
    .o_all_done         (o_all_done),
    .o_last_result      (o_last_result)
);
